>>> rtl/cable_robot_forward_kinematics_defines.svh
// ============================================================================
// Cable robot forward kinematics - assertion macros
// Concurrent check macros, compiled out when SYNTHESIS is defined.
// ============================================================================
`ifndef CABLE_ROBOT_FORWARD_KINEMATICS_DEFINES_SVH
`define CABLE_ROBOT_FORWARD_KINEMATICS_DEFINES_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define CFKM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfkm: same-cycle check failed");
// Check that cons holds in the cycle after ante.
`define CFKM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfkm: next-cycle check failed");
`else
`define CFKM_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define CFKM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/cfkm_pkg.sv
// ============================================================================
// cfkm_pkg
// Shared types, widths and codes of the trilateration pipeline.
// ============================================================================
`timescale 1ns / 1ps
package cfkm_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned NUM_W     = 68;  // signed divider numerator
    localparam int unsigned DEN_W     = 34;  // signed divider divisor
    localparam int unsigned QUO_W     = 33;  // quotient bits below overflow
    localparam int unsigned RAD_W     = 64;  // radicand
    localparam int unsigned ROOT_W    = 32;  // square root

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DEGEN   = 2'd1;
    localparam logic [1:0] ST_UNREACH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SPACING = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALONG   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACROSS  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 8'd3;

    typedef struct packed {
        logic [WORD_W-1:0] cable_o;
        logic [WORD_W-1:0] cable_p;
        logic [WORD_W-1:0] cable_q;
    } t_in_word;

    typedef struct packed {
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] pos_z;
        logic [1:0]               status;
    } t_out_word;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [WORD_W-1:0]    data;
    } t_cfg_word;

endpackage

>>> rtl/cfkm_stream_if.sv
// ============================================================================
// cfkm_stream_if
// Valid/ready channel carrying one payload word.
// ============================================================================
`timescale 1ns / 1ps
interface cfkm_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/cfkm_div.sv
// ============================================================================
// cfkm_div
// Pipelined signed divide, round to nearest, saturated to 32 bits.
// ============================================================================
`timescale 1ns / 1ps
module cfkm_div #(
    parameter int unsigned SIDE_W = 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [cfkm_pkg::NUM_W-1:0]  i_num,
    input  logic signed [cfkm_pkg::DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0]                  i_side,
    output logic                               o_valid,
    output logic signed [cfkm_pkg::WORD_W-1:0] o_quo,
    output logic [SIDE_W-1:0]                  o_side
);
    localparam int unsigned NW = cfkm_pkg::NUM_W;
    localparam int unsigned DW = cfkm_pkg::DEN_W;
    localparam int unsigned QW = cfkm_pkg::QUO_W;
    localparam int unsigned WW = cfkm_pkg::WORD_W;
    localparam int unsigned RW = NW + 2;
    localparam logic [QW-1:0] LIM_NEG = QW'(64'h8000_0000);
    localparam logic [QW-1:0] LIM_POS = QW'(64'h7fff_ffff);

    logic          num_neg;
    logic          den_neg;
    logic [NW-1:0] num_mag;
    logic [DW-1:0] den_mag;
    logic [RW-1:0] num_top;
    logic [RW-1:0] den_top;

    logic [RW-1:0]     r_rem  [0:QW];
    logic [QW-1:0]     r_quo  [0:QW];
    logic              r_neg  [0:QW];
    logic              r_ovf  [0:QW];
    logic              r_vld  [0:QW];
    logic [SIDE_W-1:0] r_side [0:QW];

    logic              r_out_vld;
    logic [WW-1:0]     r_out_quo;
    logic [SIDE_W-1:0] r_out_side;
    logic [WW-1:0]     n_out_quo;
    logic [QW-1:0]     q_fin;

    // fold signs; numerator becomes 2|n| + |dv|, divisor 2|dv|
    always_comb begin
        num_neg = i_num[NW-1];
        den_neg = i_den[DW-1];
        num_mag = num_neg ? (~i_num + 1'b1) : i_num;
        den_mag = den_neg ? (~i_den + 1'b1) : i_den;
        num_top = {1'b0, num_mag, 1'b0} + RW'(den_mag);
        den_top = RW'({den_mag, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= num_top;
            r_quo[0]  <= '0;
            r_neg[0]  <= num_neg ^ den_neg;
            r_ovf[0]  <= num_top >= (den_top << QW);
            r_side[0] <= i_side;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar s = 1; s <= QW; s++) begin : g_bit
        localparam int unsigned K = QW - s;
        logic [RW-1:0] trial;
        logic          fits;

        always_comb begin
            trial = den_top << K;
            fits  = r_rem[s-1] >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= fits ? (r_rem[s-1] - trial) : r_rem[s-1];
                r_quo[s]  <= r_quo[s-1] | (fits ? (QW'(1) << K) : '0);
                r_neg[s]  <= r_neg[s-1];
                r_ovf[s]  <= r_ovf[s-1];
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // apply sign and saturate
    always_comb begin
        q_fin = r_quo[QW];
        if (r_neg[QW]) begin
            if (r_ovf[QW] || (q_fin > LIM_NEG)) begin
                n_out_quo = 32'h8000_0000;
            end else begin
                n_out_quo = ~q_fin[WW-1:0] + 32'd1;
            end
        end else if (r_ovf[QW] || (q_fin > LIM_POS)) begin
            n_out_quo = 32'h7fff_ffff;
        end else begin
            n_out_quo = q_fin[WW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_quo  <= n_out_quo;
            r_out_side <= r_side[QW];
        end
    end

    assign o_valid = r_out_vld;
    assign o_quo   = $signed(r_out_quo);
    assign o_side  = r_out_side;

endmodule

>>> rtl/cfkm_sqrt.sv
// ============================================================================
// cfkm_sqrt
// Pipelined integer square root, floor, one result bit per stage.
// ============================================================================
`timescale 1ns / 1ps
module cfkm_sqrt #(
    parameter int unsigned SIDE_W = 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic [cfkm_pkg::RAD_W-1:0]         i_rad,
    input  logic [SIDE_W-1:0]                  i_side,
    output logic                               o_valid,
    output logic [cfkm_pkg::ROOT_W-1:0]        o_root,
    output logic [SIDE_W-1:0]                  o_side
);
    localparam int unsigned AW = cfkm_pkg::RAD_W;
    localparam int unsigned SW = cfkm_pkg::ROOT_W;

    logic [AW-1:0]     r_rem  [0:SW];
    logic [AW-1:0]     r_res  [0:SW];
    logic              r_vld  [0:SW];
    logic [SIDE_W-1:0] r_side [0:SW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_rad;
            r_res[0]  <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar s = 1; s <= SW; s++) begin : g_bit
        localparam int unsigned K = SW - s;
        logic [AW-1:0] probe;
        logic [AW-1:0] trial;
        logic          fits;

        always_comb begin
            probe = AW'(1) << (2 * K);
            trial = r_res[s-1] + probe;
            fits  = r_rem[s-1] >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= fits ? (r_rem[s-1] - trial) : r_rem[s-1];
                r_res[s]  <= fits ? ((r_res[s-1] >> 1) + probe) : (r_res[s-1] >> 1);
                r_side[s] <= r_side[s-1];
            end
        end
    end

    assign o_valid = r_vld[SW];
    assign o_root  = r_res[SW][SW-1:0];
    assign o_side  = r_side[SW];

endmodule

>>> rtl/cable_robot_forward_kinematics.sv
// ============================================================================
// cable_robot_forward_kinematics
// Three-sphere trilateration of a cable robot's hanging point, Q16.16.
// ============================================================================
//
//  port      dir  word                             accepted when
//  --------  ---  -------------------------------  ---------------------
//  i_item    in   cable_o, cable_p, cable_q         valid & ready
//  o_result  out  pos_x, pos_y, pos_z, status       valid & ready
//  i_cfg     in   index, data (register write)      valid & ready
//
//  One word enters per cycle unless a result waits unread at the output.
//  Depth is set by the two 35-stage dividers (y, then x, which needs
//  y) and the 33-stage square root, each resolving one bit per stage.
//  Reset clears the valid bits and loads 1.0 into all four registers.
//  One enable moves the whole pipe: it holds while a result waits unread,
//  and the output register advances as soon as it is taken.
//
`timescale 1ns / 1ps
`include "cable_robot_forward_kinematics_defines.svh"
module cable_robot_forward_kinematics #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cfkm_stream_if.sink          i_item,
    cfkm_stream_if.source        o_result,
    cfkm_stream_if.sink          i_cfg
);
    localparam int unsigned WW = cfkm_pkg::WORD_W;
    localparam int unsigned NW = cfkm_pkg::NUM_W;
    localparam int unsigned AW = cfkm_pkg::RAD_W;
    localparam int unsigned SW = cfkm_pkg::ROOT_W;
    localparam int unsigned PW = 2 * WW;
    localparam logic [WW-1:0] RST_ONE = 32'd1 << FRAC_BITS;
    localparam int unsigned YSIDE_W = PW + NW;
    localparam int unsigned XSIDE_W = PW + WW;
    localparam int unsigned RSIDE_W = 2 * WW + 1;

    // configuration registers
    logic [WW-1:0]        r_spacing;
    logic signed [WW-1:0] r_along;
    logic signed [WW-1:0] r_across;
    logic signed [WW-1:0] r_height;
    logic                 degen;

    // global advance
    logic en;

    // stage A: captured lengths
    logic          r_a_vld;
    logic [WW-1:0] r_a_lo, r_a_lp, r_a_lq;

    // stage B: squares
    logic                 r_b_vld;
    logic [PW-1:0]        r_b_sqo, r_b_sqp, r_b_sqq, r_b_dd;
    logic signed [PW-1:0] r_b_ii, r_b_jj;

    // stage C: numerators
    logic                 r_c_vld;
    logic [PW-1:0]        r_c_sqo;
    logic signed [NW-1:0] r_c_ny, r_c_nq;

    // y divider
    logic                 y_vld;
    logic signed [WW-1:0] y_val;
    logic [YSIDE_W-1:0]   y_side;

    // stage D: i*y
    logic                 r_d_vld;
    logic [PW-1:0]        r_d_sqo;
    logic signed [NW-1:0] r_d_nq;
    logic signed [WW-1:0] r_d_y;
    logic signed [PW-1:0] r_d_iy;

    // stage E: x numerator
    logic                 r_e_vld;
    logic [PW-1:0]        r_e_sqo;
    logic signed [WW-1:0] r_e_y;
    logic signed [NW-1:0] r_e_nx;

    // x divider
    logic                 x_vld;
    logic signed [WW-1:0] x_val;
    logic [XSIDE_W-1:0]   x_side;
    logic [PW-1:0]        x_sqo;
    logic signed [WW-1:0] x_y;

    // stage F: x^2, y^2
    logic                 r_f_vld;
    logic [PW-1:0]        r_f_sqo;
    logic signed [WW-1:0] r_f_x, r_f_y;
    logic signed [PW-1:0] r_f_xx, r_f_yy;

    // stage G: radicand
    logic                 r_g_vld;
    logic signed [WW-1:0] r_g_x, r_g_y;
    logic [AW-1:0]        r_g_rad;
    logic                 r_g_neg;
    logic signed [PW+1:0] rad_full;

    // square root
    logic                 s_vld;
    logic [SW-1:0]        s_root;
    logic [RSIDE_W-1:0]   s_side;
    logic signed [WW-1:0] s_x, s_y;
    logic                 s_neg;

    // output register
    logic                    r_out_vld;
    cfkm_pkg::t_out_word     r_out;
    cfkm_pkg::t_out_word     n_out;
    logic signed [WW+1:0]    z_diff;
    logic [WW-1:0]           z_sat;

    // ------------------------------------------------------------------
    // Configuration: always ready, out-of-range indexes drop the write
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= RST_ONE;
            r_along   <= RST_ONE;
            r_across  <= RST_ONE;
            r_height  <= RST_ONE;
        end else if (i_cfg.valid) begin
            case (i_cfg.payload.index)
                cfkm_pkg::REG_SPACING: r_spacing <= i_cfg.payload.data;
                cfkm_pkg::REG_ALONG:   r_along   <= i_cfg.payload.data;
                cfkm_pkg::REG_ACROSS:  r_across  <= i_cfg.payload.data;
                cfkm_pkg::REG_HEIGHT:  r_height  <= i_cfg.payload.data;
                default: ;
            endcase
        end
    end

    assign degen = (r_spacing == '0) || (r_across == '0);

    // ------------------------------------------------------------------
    // Pipe enable: advance unless a finished result is stalled
    // ------------------------------------------------------------------
    assign en           = !r_out_vld || o_result.ready;
    assign i_item.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_item.valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= y_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= x_vld;
            r_g_vld <= r_f_vld;
        end
    end

    // stage A..C: capture, square, form the y numerator and the fixed part
    // of the x numerator (lO^2 - lQ^2 + i^2 + j^2)
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_lo  <= i_item.payload.cable_o;
            r_a_lp  <= i_item.payload.cable_p;
            r_a_lq  <= i_item.payload.cable_q;

            r_b_sqo <= PW'(r_a_lo) * PW'(r_a_lo);
            r_b_sqp <= PW'(r_a_lp) * PW'(r_a_lp);
            r_b_sqq <= PW'(r_a_lq) * PW'(r_a_lq);
            r_b_dd  <= PW'(r_spacing) * PW'(r_spacing);
            r_b_ii  <= PW'(r_along) * PW'(r_along);
            r_b_jj  <= PW'(r_across) * PW'(r_across);

            r_c_sqo <= r_b_sqo;
            r_c_ny  <= $signed(NW'(r_b_sqo)) - $signed(NW'(r_b_sqp))
                       + $signed(NW'(r_b_dd));
            r_c_nq  <= $signed(NW'(r_b_sqo)) - $signed(NW'(r_b_sqq))
                       + NW'(r_b_ii) + NW'(r_b_jj);
        end
    end

    // y = round(ny / 2d)
    cfkm_div #(
        .SIDE_W (YSIDE_W)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_vld),
        .i_num   (r_c_ny),
        .i_den   ($signed({1'b0, r_spacing, 1'b0})),
        .i_side  ({r_c_sqo, r_c_nq}),
        .o_valid (y_vld),
        .o_quo   (y_val),
        .o_side  (y_side)
    );

    // stage D, E: subtract 2*i*y from the x numerator
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_sqo <= y_side[YSIDE_W-1:NW];
            r_d_nq  <= $signed(y_side[NW-1:0]);
            r_d_y   <= y_val;
            r_d_iy  <= PW'(r_along) * PW'(y_val);

            r_e_sqo <= r_d_sqo;
            r_e_y   <= r_d_y;
            r_e_nx  <= r_d_nq - NW'(r_d_iy) - NW'(r_d_iy);
        end
    end

    // x = round(nx / 2j)
    cfkm_div #(
        .SIDE_W (XSIDE_W)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_e_vld),
        .i_num   (r_e_nx),
        .i_den   ($signed({r_across[WW-1], r_across, 1'b0})),
        .i_side  ({r_e_sqo, r_e_y}),
        .o_valid (x_vld),
        .o_quo   (x_val),
        .o_side  (x_side)
    );

    assign x_sqo = x_side[XSIDE_W-1:WW];
    assign x_y   = $signed(x_side[WW-1:0]);

    // stage F, G: radicand lO^2 - x^2 - y^2
    assign rad_full = $signed((PW+2)'(r_f_sqo)) - (PW+2)'(r_f_xx) - (PW+2)'(r_f_yy);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_sqo <= x_sqo;
            r_f_x   <= x_val;
            r_f_y   <= x_y;
            r_f_xx  <= PW'(x_val) * PW'(x_val);
            r_f_yy  <= PW'(x_y) * PW'(x_y);

            r_g_x   <= r_f_x;
            r_g_y   <= r_f_y;
            r_g_rad <= rad_full[AW-1:0];
            r_g_neg <= rad_full[PW+1];
        end
    end

    cfkm_sqrt #(
        .SIDE_W (RSIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_g_vld),
        .i_rad   (r_g_rad),
        .i_side  ({r_g_x, r_g_y, r_g_neg}),
        .o_valid (s_vld),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    assign s_x   = $signed(s_side[RSIDE_W-1:WW+1]);
    assign s_y   = $signed(s_side[WW:1]);
    assign s_neg = s_side[0];

    // ------------------------------------------------------------------
    // Final: z = height - root, saturated; pick status
    // ------------------------------------------------------------------
    assign z_diff = (WW+2)'(r_height) - $signed((WW+2)'(s_root));

    always_comb begin
        if (z_diff[WW+1:WW-1] == 3'b000 || z_diff[WW+1:WW-1] == 3'b111) begin
            z_sat = z_diff[WW-1:0];
        end else if (z_diff[WW+1]) begin
            z_sat = 32'h8000_0000;
        end else begin
            z_sat = 32'h7fff_ffff;
        end

        if (degen) begin
            n_out.pos_x  = '0;
            n_out.pos_y  = '0;
            n_out.pos_z  = r_height;
            n_out.status = cfkm_pkg::ST_DEGEN;
        end else if (s_neg) begin
            n_out.pos_x  = s_x;
            n_out.pos_y  = s_y;
            n_out.pos_z  = r_height;
            n_out.status = cfkm_pkg::ST_UNREACH;
        end else begin
            n_out.pos_x  = s_x;
            n_out.pos_y  = s_y;
            n_out.pos_z  = $signed(z_sat);
            n_out.status = cfkm_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid   = r_out_vld;
    assign o_result.payload = r_out;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `CFKM_ASSERT_NOW(a_degen_status, i_clk, i_rst_n, o_result.valid && degen, o_result.payload.status == cfkm_pkg::ST_DEGEN)
    `CFKM_ASSERT_NOW(a_degen_plane, i_clk, i_rst_n, o_result.valid && (o_result.payload.status == cfkm_pkg::ST_DEGEN), o_result.payload.pos_x == '0 && o_result.payload.pos_y == '0)
    `CFKM_ASSERT_NOW(a_unreach_height, i_clk, i_rst_n, o_result.valid && (o_result.payload.status == cfkm_pkg::ST_UNREACH), o_result.payload.pos_z == r_height)

endmodule
